// File: src/dpt_pkg.sv
package dpt_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_CENTER_X     = 3'd0;
  localparam logic [2:0] CFG_CENTER_Y     = 3'd1;
  localparam logic [2:0] CFG_INV_FOCAL_X  = 3'd2;
  localparam logic [2:0] CFG_INV_FOCAL_Y  = 3'd3;
  localparam logic [2:0] CFG_COLOR_ENABLE = 3'd4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Register reset values.
  localparam logic [17:0] CENTER_X_RST    = 18'd80304;
  localparam logic [16:0] CENTER_Y_RST    = 17'd66309;
  localparam logic [23:0] INV_FOCAL_X_RST = 24'd31873;
  localparam logic [23:0] INV_FOCAL_Y_RST = 24'd31873;

  // Width of the low half when a product operand is split in two.
  localparam int SPLIT_W = 17;

  // Wide accumulator widths.
  localparam int Q_W   = 60;
  localparam int ACC_W = 62;

  // Rounding constants: half of the last kept unit.
  localparam logic signed [Q_W-1:0] HALF24   = Q_W'(1) <<< 23;
  localparam logic signed [Q_W-1:0] HALF28   = Q_W'(1) <<< 27;
  localparam logic signed [ACC_W-1:0] HALF28_ACC = ACC_W'(1) <<< 27;

  // Camera translation in Q.8 millimeters.
  localparam int TR_X = -189;
  localparam int TR_Y = 30;
  localparam int TR_Z = 113;

  // Translation folded into the Q.32 to Q.8 rounding add.
  localparam logic signed [Q_W-1:0] P0_BIAS = HALF24 - (Q_W'(TR_X) <<< 24);
  localparam logic signed [Q_W-1:0] P1_BIAS = HALF24 - (Q_W'(TR_Y) <<< 24);

  // Transposed rotation, Q0.24.
  localparam logic signed [24:0] ROT_T [3][3] = '{
    '{ 25'sd15940804,  -25'sd285474,   -25'sd5223432},
    '{ 25'sd312764,     25'sd16774258,  25'sd37731},
    '{ 25'sd5221869,   -25'sd133226,   25'sd15943316}
  };

  // World offset (900, 0, 180) mm in Q.32.
  localparam logic signed [ACC_W-1:0] WORLD_OFF [3] = '{
    62'sd3865470566400, 62'sd0, 62'sd773094113280
  };

  localparam logic signed [33:0] SAT_MAX = 34'sd8388607;
  localparam logic signed [33:0] SAT_MIN = -34'sd8388608;

  typedef struct packed {
    logic [17:0] center_x;
    logic [16:0] center_y;
    logic [23:0] inv_focal_x;
    logic [23:0] inv_focal_y;
    logic        color_enable;
  } cfg_t;

  // Fields that ride along the projection stages.
  typedef struct packed {
    logic               sel;
    logic [19:0]        z0;
    logic signed [24:0] p2;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } pass_t;

  // Projection result handed to the rotation stages.
  typedef struct packed {
    pass_t              pass;
    logic signed [30:0] x0;
    logic signed [29:0] y0;
    logic signed [34:0] p0;
    logic signed [33:0] p1;
  } proj_t;

  // Final point and color.
  typedef struct packed {
    logic               sel;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic signed [23:0] point_z;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } res_t;

  // Clamp to the 24-bit signed output range.
  function automatic logic signed [23:0] sat24(input logic signed [33:0] v);
    logic signed [23:0] r;
    if (v > SAT_MAX) begin
      r = 24'sh7FFFFF;
    end else if (v < SAT_MIN) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

// File: src/dpt_cfg.sv
module dpt_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [dpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dpt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output dpt_pkg::cfg_t                  cfg
);
  import dpt_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write; unknown indexes leave everything unchanged.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_CENTER_X:     cfg_nxt.center_x     = cfg_wdata[17:0];
        CFG_CENTER_Y:     cfg_nxt.center_y     = cfg_wdata[16:0];
        CFG_INV_FOCAL_X:  cfg_nxt.inv_focal_x  = cfg_wdata;
        CFG_INV_FOCAL_Y:  cfg_nxt.inv_focal_y  = cfg_wdata;
        CFG_COLOR_ENABLE: cfg_nxt.color_enable = cfg_wdata[0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_x     <= CENTER_X_RST;
      cfg_r.center_y     <= CENTER_Y_RST;
      cfg_r.inv_focal_x  <= INV_FOCAL_X_RST;
      cfg_r.inv_focal_y  <= INV_FOCAL_Y_RST;
      cfg_r.color_enable <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: src/dpt_proj.sv
module dpt_proj (
  input  logic           clk,
  input  logic           rst_n,
  input  dpt_pkg::cfg_t  cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_camera_select,
  input  logic [9:0]     in_column,
  input  logic [8:0]     in_row,
  input  logic [15:0]    in_depth,
  input  logic [7:0]     in_first_byte,
  input  logic [7:0]     in_second_byte,
  input  logic [7:0]     in_third_byte,
  output logic           out_valid,
  input  logic           out_ready,
  output dpt_pkg::proj_t out_data
);
  import dpt_pkg::*;

  logic [3:0] v_r;
  logic [3:0] ld;

  // Stage 1: offset from the optical center times depth.
  logic signed [18:0] dx;
  logic signed [17:0] dy;
  logic signed [34:0] ad_x_nxt, ad_x_r;
  logic signed [33:0] ad_y_nxt, ad_y_r;
  pass_t              pass1_nxt, pass1_r;

  // Stage 2: partial products with the reciprocal focal lengths.
  logic signed [42:0] mxl_nxt, mxl_r, mxh_nxt, mxh_r;
  logic signed [42:0] myl_nxt, myl_r, myh_nxt, myh_r;
  pass_t              pass2_r;

  // Stage 3: full Q.32 coordinates.
  logic signed [Q_W-1:0] xq_nxt, xq_r, yq_nxt, yq_r;
  pass_t                 pass3_r;

  // Stage 4: rounding.
  logic signed [Q_W-1:0] sx, sy, x0_sum, y0_sum, p0_sum, p1_sum;
  proj_t                 out_nxt, out_r;

  // A stage loads when it is empty or its contents move on.
  always_comb begin
    ld[3] = ~v_r[3] | out_ready;
    ld[2] = ~v_r[2] | ld[3];
    ld[1] = ~v_r[1] | ld[2];
    ld[0] = ~v_r[0] | ld[1];
  end

  assign in_ready  = ld[0];
  assign out_valid = v_r[3];
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) v_r[0] <= in_valid;
      if (ld[1]) v_r[1] <= v_r[0];
      if (ld[2]) v_r[2] <= v_r[1];
      if (ld[3]) v_r[3] <= v_r[2];
    end
  end

  // Stage 1 logic.
  always_comb begin
    dx = $signed({1'b0, in_column, 8'd0}) - $signed({1'b0, cfg.center_x});
    dy = $signed({1'b0, in_row, 8'd0}) - $signed({1'b0, cfg.center_y});
    ad_x_nxt = 35'(dx) * 35'($signed({1'b0, in_depth}));
    ad_y_nxt = 34'(dy) * 34'($signed({1'b0, in_depth}));
    pass1_nxt.sel   = in_camera_select;
    pass1_nxt.z0    = {in_depth, 4'd0};
    pass1_nxt.p2    = $signed({1'b0, in_depth, 8'd0}) - 25'(TR_Z);
    pass1_nxt.red   = cfg.color_enable ? in_third_byte  : 8'hFF;
    pass1_nxt.green = cfg.color_enable ? in_second_byte : 8'hFF;
    pass1_nxt.blue  = cfg.color_enable ? in_first_byte  : 8'hFF;
  end

  // Stage 2 logic: split the depth product in a low and a high part.
  always_comb begin
    mxl_nxt = 43'($signed({1'b0, ad_x_r[SPLIT_W-1:0]}))
            * 43'($signed({1'b0, cfg.inv_focal_x}));
    mxh_nxt = 43'($signed(ad_x_r[34:SPLIT_W]))
            * 43'($signed({1'b0, cfg.inv_focal_x}));
    myl_nxt = 43'($signed({1'b0, ad_y_r[SPLIT_W-1:0]}))
            * 43'($signed({1'b0, cfg.inv_focal_y}));
    myh_nxt = 43'($signed(ad_y_r[33:SPLIT_W]))
            * 43'($signed({1'b0, cfg.inv_focal_y}));
  end

  // Stage 3 logic: recombine the partial products.
  always_comb begin
    xq_nxt = (Q_W'(mxh_r) <<< SPLIT_W) + Q_W'(mxl_r);
    yq_nxt = (Q_W'(myh_r) <<< SPLIT_W) + Q_W'(myl_r);
  end

  // Stage 4 logic: round half away from zero, with the translation folded in.
  always_comb begin
    sx     = {{(Q_W-1){1'b0}}, xq_r[Q_W-1]};
    sy     = {{(Q_W-1){1'b0}}, yq_r[Q_W-1]};
    x0_sum = xq_r + HALF28 - sx;
    y0_sum = yq_r + HALF28 - sy;
    p0_sum = xq_r + P0_BIAS - sx;
    p1_sum = yq_r + P1_BIAS - sy;
    out_nxt.pass = pass3_r;
    out_nxt.x0   = x0_sum[58:28];
    out_nxt.y0   = y0_sum[57:28];
    out_nxt.p0   = p0_sum[58:24];
    out_nxt.p1   = p1_sum[57:24];
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      ad_x_r  <= ad_x_nxt;
      ad_y_r  <= ad_y_nxt;
      pass1_r <= pass1_nxt;
    end
    if (ld[1]) begin
      mxl_r   <= mxl_nxt;
      mxh_r   <= mxh_nxt;
      myl_r   <= myl_nxt;
      myh_r   <= myh_nxt;
      pass2_r <= pass1_r;
    end
    if (ld[2]) begin
      xq_r    <= xq_nxt;
      yq_r    <= yq_nxt;
      pass3_r <= pass2_r;
    end
    if (ld[3]) begin
      out_r <= out_nxt;
    end
  end

`ifndef ASSERT_OFF
  // An accepted transaction always lands in the first stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v_r[0])
    else $error("accepted transaction lost at projection entry");

  // Input is refused only when every projection stage is occupied.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&v_r))
    else $error("projection stalls with a bubble inside");
`endif

endmodule

// File: src/dpt_rot.sv
module dpt_rot (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  dpt_pkg::proj_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output dpt_pkg::res_t  out_data
);
  import dpt_pkg::*;

  // Camera 0 point and color carried alongside the rotation.
  typedef struct packed {
    logic               sel;
    logic signed [30:0] x0;
    logic signed [29:0] y0;
    logic [19:0]        z0;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } hold_t;

  logic [3:0] v_r;
  logic [3:0] ld;

  hold_t hold_nxt, hold1_r, hold2_r, hold3_r;

  // Stage 1: rotation partial products, one lane per output axis.
  logic signed [42:0] m0l_nxt [3], m0h_nxt [3], m1l_nxt [3], m1h_nxt [3];
  logic signed [42:0] m0l_r [3], m0h_r [3], m1l_r [3], m1h_r [3];
  logic signed [49:0] m2_nxt [3], m2_r [3], m2b_r [3];

  // Stage 2: recombined terms.
  logic signed [ACC_W-1:0] t0_nxt [3], t1_nxt [3], t0_r [3], t1_r [3];

  // Stage 3: rotated sum plus world offset.
  logic signed [ACC_W-1:0] acc_nxt [3], acc_r [3];

  // Stage 4: rounding, camera select and saturation.
  logic signed [ACC_W-1:0] rnd [3];
  logic signed [33:0]      pre_x, pre_y, pre_z;
  res_t                    out_nxt, out_r;

  always_comb begin
    ld[3] = ~v_r[3] | out_ready;
    ld[2] = ~v_r[2] | ld[3];
    ld[1] = ~v_r[1] | ld[2];
    ld[0] = ~v_r[0] | ld[1];
  end

  assign in_ready  = ld[0];
  assign out_valid = v_r[3];
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) v_r[0] <= in_valid;
      if (ld[1]) v_r[1] <= v_r[0];
      if (ld[2]) v_r[2] <= v_r[1];
      if (ld[3]) v_r[3] <= v_r[2];
    end
  end

  // Stage 1 logic.
  always_comb begin
    hold_nxt.sel   = in_data.pass.sel;
    hold_nxt.x0    = in_data.x0;
    hold_nxt.y0    = in_data.y0;
    hold_nxt.z0    = in_data.pass.z0;
    hold_nxt.red   = in_data.pass.red;
    hold_nxt.green = in_data.pass.green;
    hold_nxt.blue  = in_data.pass.blue;
    for (int k = 0; k < 3; k++) begin
      m0l_nxt[k] = 43'(ROT_T[k][0]) * 43'($signed({1'b0, in_data.p0[SPLIT_W-1:0]}));
      m0h_nxt[k] = 43'(ROT_T[k][0]) * 43'($signed(in_data.p0[34:SPLIT_W]));
      m1l_nxt[k] = 43'(ROT_T[k][1]) * 43'($signed({1'b0, in_data.p1[SPLIT_W-1:0]}));
      m1h_nxt[k] = 43'(ROT_T[k][1]) * 43'($signed(in_data.p1[33:SPLIT_W]));
      m2_nxt[k]  = 50'(ROT_T[k][2]) * 50'(in_data.pass.p2);
    end
  end

  // Stage 2 logic.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      t0_nxt[k] = (ACC_W'(m0h_r[k]) <<< SPLIT_W) + ACC_W'(m0l_r[k]);
      t1_nxt[k] = (ACC_W'(m1h_r[k]) <<< SPLIT_W) + ACC_W'(m1l_r[k]);
    end
  end

  // Stage 3 logic.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc_nxt[k] = t0_r[k] + t1_r[k] + ACC_W'(m2b_r[k]) + WORLD_OFF[k];
    end
  end

  // Stage 4 logic: round Q.32 to Q.4 half away from zero, pick the pose.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rnd[k] = acc_r[k] + HALF28_ACC - ACC_W'({1'b0, acc_r[k][ACC_W-1]});
    end
    if (hold3_r.sel) begin
      pre_x = rnd[0][61:28];
      pre_y = rnd[1][61:28];
      pre_z = rnd[2][61:28];
    end else begin
      pre_x = 34'(hold3_r.x0);
      pre_y = 34'(hold3_r.y0);
      pre_z = $signed({14'd0, hold3_r.z0});
    end
    out_nxt.sel     = hold3_r.sel;
    out_nxt.point_x = sat24(pre_x);
    out_nxt.point_y = sat24(pre_y);
    out_nxt.point_z = sat24(pre_z);
    out_nxt.red     = hold3_r.red;
    out_nxt.green   = hold3_r.green;
    out_nxt.blue    = hold3_r.blue;
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      m0l_r   <= m0l_nxt;
      m0h_r   <= m0h_nxt;
      m1l_r   <= m1l_nxt;
      m1h_r   <= m1h_nxt;
      m2_r    <= m2_nxt;
      hold1_r <= hold_nxt;
    end
    if (ld[1]) begin
      t0_r    <= t0_nxt;
      t1_r    <= t1_nxt;
      m2b_r   <= m2_r;
      hold2_r <= hold1_r;
    end
    if (ld[2]) begin
      acc_r   <= acc_nxt;
      hold3_r <= hold2_r;
    end
    if (ld[3]) begin
      out_r <= out_nxt;
    end
  end

`ifndef ASSERT_OFF
  // Input is refused only when every rotation stage is occupied.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&v_r))
    else $error("rotation stalls with a bubble inside");

  // A camera 0 point has Z equal to depth in Q.4: whole, non-negative.
  a_cam0_z: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[3] && !out_r.sel |-> (out_r.point_z[3:0] == 4'd0) && !out_r.point_z[23])
    else $error("camera 0 depth scaling broken");
`endif

endmodule

// File: src/depth_pixel_to_point_transform_unit.sv
// Channel  | Handshake             | Payload
// ---------+-----------------------+------------------------------------------------
// in       | in_valid / in_ready   | camera_select, column, row, depth, 3 color bytes
// out      | out_valid / out_ready | point_x, point_y, point_z, red, green, blue
// cfg      | cfg_we                | cfg_index, cfg_wdata (write only)
//
// One pixel per cycle is accepted while results keep moving; a result passes through eight
// registered stages: four back-projection stages, four rotation stages.
// Synchronous active-low reset clears all stage valid bits and restores the registers.
// On a stall ready ripples back only through full stages, so bubbles are squeezed
// out and input is refused only when all eight stages hold a transaction.
module depth_pixel_to_point_transform_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [dpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dpt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_camera_select,
  input  logic [9:0]                     in_column,
  input  logic [8:0]                     in_row,
  input  logic [15:0]                    in_depth,
  input  logic [7:0]                     in_first_byte,
  input  logic [7:0]                     in_second_byte,
  input  logic [7:0]                     in_third_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [23:0]             out_point_x,
  output logic signed [23:0]             out_point_y,
  output logic signed [23:0]             out_point_z,
  output logic [7:0]                     out_red,
  output logic [7:0]                     out_green,
  output logic [7:0]                     out_blue
);
  import dpt_pkg::*;

  cfg_t  cfg;
  proj_t proj_data;
  res_t  res;
  logic  proj_valid;
  logic  proj_ready;

  // Configuration registers.
  dpt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Pinhole back-projection.
  dpt_proj u_proj (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_camera_select (in_camera_select),
    .in_column        (in_column),
    .in_row           (in_row),
    .in_depth         (in_depth),
    .in_first_byte    (in_first_byte),
    .in_second_byte   (in_second_byte),
    .in_third_byte    (in_third_byte),
    .out_valid        (proj_valid),
    .out_ready        (proj_ready),
    .out_data         (proj_data)
  );

  // Rigid pose, rounding and saturation.
  dpt_rot u_rot (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (proj_valid),
    .in_ready  (proj_ready),
    .in_data   (proj_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (res)
  );

  assign out_point_x = res.point_x;
  assign out_point_y = res.point_y;
  assign out_point_z = res.point_z;
  assign out_red     = res.red;
  assign out_green   = res.green;
  assign out_blue    = res.blue;

endmodule

// File: bench/point_stream_checker.sv
`timescale 1ns / 1ps

// Watches the configuration port and both channels of the depth-to-point unit.
// It predicts every output point from its own copy of the registers and compares the
// results in order.
module point_stream_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [dpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dpt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           in_camera_select,
  input  logic [9:0]                     in_column,
  input  logic [8:0]                     in_row,
  input  logic [15:0]                    in_depth,
  input  logic [7:0]                     in_first_byte,
  input  logic [7:0]                     in_second_byte,
  input  logic [7:0]                     in_third_byte,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic signed [23:0]             out_point_x,
  input  logic signed [23:0]             out_point_y,
  input  logic signed [23:0]             out_point_z,
  input  logic [7:0]                     out_red,
  input  logic [7:0]                     out_green,
  input  logic [7:0]                     out_blue,
  output int                             error_count,
  output int                             pending_points
);

  // Camera 1 pose: translation in Q.8 mm, transposed rotation in Q0.24.
  localparam longint POSE_TX = -189;
  localparam longint POSE_TY = 30;
  localparam longint POSE_TZ = 113;
  localparam longint R00 = 15940804;
  localparam longint R01 = -285474;
  localparam longint R02 = -5223432;
  localparam longint R10 = 312764;
  localparam longint R11 = 16774258;
  localparam longint R12 = 37731;
  localparam longint R20 = 5221869;
  localparam longint R21 = -133226;
  localparam longint R22 = 15943316;
  localparam longint WORLD_X = 900;
  localparam longint WORLD_Y = 0;
  localparam longint WORLD_Z = 180;

  localparam longint SAT_HI = 8388607;
  localparam longint SAT_LO = -8388608;

  typedef struct packed {
    logic [23:0] point_x;
    logic [23:0] point_y;
    logic [23:0] point_z;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } world_point_t;

  // Shadow copy of the configuration registers.
  logic [17:0] center_x;
  logic [16:0] center_y;
  logic [23:0] inv_focal_x;
  logic [23:0] inv_focal_y;
  logic        color_enable;

  world_point_t expected_points[$];
  int           mismatch_count;

  // Divide by 2^s, rounding to nearest with ties away from zero.
  function automatic longint round_half_away(input longint v, input int s);
    longint half;
    half = 64'sd1 <<< (s - 1);
    if (v >= 0) return (v + half) >>> s;
    return -(((-v) + half) >>> s);
  endfunction

  function automatic logic [23:0] clamp_q20_4(input longint v);
    if (v > SAT_HI) return 24'h7FFFFF;
    if (v < SAT_LO) return 24'h800000;
    return v[23:0];
  endfunction

  // Back-projects one pixel and, for camera 1, moves it into the world frame.
  function automatic world_point_t backproject_pixel(
    input logic        sel,
    input logic [9:0]  u,
    input logic [8:0]  v,
    input logic [15:0] d,
    input logic [7:0]  blue_in,
    input logic [7:0]  green_in,
    input logic [7:0]  red_in
  );
    longint       dl;
    longint       xq;
    longint       yq;
    longint       tx;
    longint       ty;
    longint       tz;
    longint       px;
    longint       py;
    longint       pz;
    world_point_t pt;
    dl = longint'(d);
    xq = (longint'(u) * 256 - longint'(center_x)) * dl * longint'(inv_focal_x);
    yq = (longint'(v) * 256 - longint'(center_y)) * dl * longint'(inv_focal_y);
    if (!sel) begin
      px = round_half_away(xq, 28);
      py = round_half_away(yq, 28);
      pz = dl * 16;
    end else begin
      tx = round_half_away(xq, 24) - POSE_TX;
      ty = round_half_away(yq, 24) - POSE_TY;
      tz = dl * 256 - POSE_TZ;
      px = round_half_away(R00 * tx + R01 * ty + R02 * tz + (WORLD_X <<< 32), 28);
      py = round_half_away(R10 * tx + R11 * ty + R12 * tz + (WORLD_Y <<< 32), 28);
      pz = round_half_away(R20 * tx + R21 * ty + R22 * tz + (WORLD_Z <<< 32), 28);
    end
    pt.point_x = clamp_q20_4(px);
    pt.point_y = clamp_q20_4(py);
    pt.point_z = clamp_q20_4(pz);
    if (color_enable) begin
      pt.red   = red_in;
      pt.green = green_in;
      pt.blue  = blue_in;
    end else begin
      pt.red   = 8'hFF;
      pt.green = 8'hFF;
      pt.blue  = 8'hFF;
    end
    return pt;
  endfunction

  // Track register writes, check each result transaction, then queue a prediction
  // for each accepted pixel.
  always @(posedge clk) begin
    world_point_t want;
    if (!rst_n) begin
      center_x     = 18'd80304;
      center_y     = 17'd66309;
      inv_focal_x  = 24'd31873;
      inv_focal_y  = 24'd31873;
      color_enable = 1'b1;
      expected_points.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          dpt_pkg::CFG_CENTER_X:     center_x = cfg_wdata[17:0];
          dpt_pkg::CFG_CENTER_Y:     center_y = cfg_wdata[16:0];
          dpt_pkg::CFG_INV_FOCAL_X:  inv_focal_x = cfg_wdata[23:0];
          dpt_pkg::CFG_INV_FOCAL_Y:  inv_focal_y = cfg_wdata[23:0];
          dpt_pkg::CFG_COLOR_ENABLE: color_enable = cfg_wdata[0];
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          $error("unexpected result: point_x %0d point_y %0d point_z %0d",
                 out_point_x, out_point_y, out_point_z);
          mismatch_count++;
        end else begin
          want = expected_points.pop_front();
          if (out_point_x !== want.point_x) begin
            $error("point_x: expected %0d, actual %0d", $signed(want.point_x), out_point_x);
            mismatch_count++;
          end
          if (out_point_y !== want.point_y) begin
            $error("point_y: expected %0d, actual %0d", $signed(want.point_y), out_point_y);
            mismatch_count++;
          end
          if (out_point_z !== want.point_z) begin
            $error("point_z: expected %0d, actual %0d", $signed(want.point_z), out_point_z);
            mismatch_count++;
          end
          if (out_red !== want.red) begin
            $error("red: expected %0d, actual %0d", want.red, out_red);
            mismatch_count++;
          end
          if (out_green !== want.green) begin
            $error("green: expected %0d, actual %0d", want.green, out_green);
            mismatch_count++;
          end
          if (out_blue !== want.blue) begin
            $error("blue: expected %0d, actual %0d", want.blue, out_blue);
            mismatch_count++;
          end
        end
      end

      if (in_valid && in_ready) begin
        expected_points.push_back(backproject_pixel(in_camera_select, in_column, in_row,
                                                    in_depth, in_first_byte,
                                                    in_second_byte, in_third_byte));
      end
    end
    error_count    <= mismatch_count;
    pending_points <= expected_points.size();
  end

endmodule

// File: bench/depth_pixel_to_point_transform_unit_tb.sv
`timescale 1ns / 1ps

module depth_pixel_to_point_transform_unit_tb;

  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 60;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 175;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [dpt_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [dpt_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                           in_valid;
  logic                           in_ready;
  logic                           in_camera_select;
  logic [9:0]                     in_column;
  logic [8:0]                     in_row;
  logic [15:0]                    in_depth;
  logic [7:0]                     in_first_byte;
  logic [7:0]                     in_second_byte;
  logic [7:0]                     in_third_byte;
  logic                           out_valid;
  logic                           out_ready;
  logic signed [23:0]             out_point_x;
  logic signed [23:0]             out_point_y;
  logic signed [23:0]             out_point_z;
  logic [7:0]                     out_red;
  logic [7:0]                     out_green;
  logic [7:0]                     out_blue;

  int   error_count;
  int   pending_points;
  bit   hold_request;
  bit   sender_steady;
  bit   receiver_steady;
  int   pixels_sent;

  depth_pixel_to_point_transform_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_camera_select (in_camera_select),
    .in_column        (in_column),
    .in_row           (in_row),
    .in_depth         (in_depth),
    .in_first_byte    (in_first_byte),
    .in_second_byte   (in_second_byte),
    .in_third_byte    (in_third_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_point_x      (out_point_x),
    .out_point_y      (out_point_y),
    .out_point_z      (out_point_z),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue)
  );

  point_stream_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_camera_select (in_camera_select),
    .in_column        (in_column),
    .in_row           (in_row),
    .in_depth         (in_depth),
    .in_first_byte    (in_first_byte),
    .in_second_byte   (in_second_byte),
    .in_third_byte    (in_third_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_point_x      (out_point_x),
    .out_point_y      (out_point_y),
    .out_point_z      (out_point_z),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .error_count      (error_count),
    .pending_points   (pending_points)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offers one pixel after a random gap and holds it until the transaction completes.
  // Valid is lowered only when a gap follows, so back-to-back pixels keep it high.
  task automatic send_pixel(
    input logic        sel,
    input logic [9:0]  u,
    input logic [8:0]  v,
    input logic [15:0] d,
    input logic [7:0]  b0,
    input logic [7:0]  b1,
    input logic [7:0]  b2
  );
    int gap;
    if (pixels_sent % 64 == 0) sender_steady = ($urandom_range(0, 3) == 0);
    pixels_sent++;
    gap = sender_steady ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_camera_select <= sel;
    in_column        <= u;
    in_row           <= v;
    in_depth         <= d;
    in_first_byte    <= b0;
    in_second_byte   <= b1;
    in_third_byte    <= b2;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops offering pixels and waits until every predicted point has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_points != 0);
  endtask

  task automatic write_register(input logic [dpt_pkg::CFG_IDX_W-1:0] idx,
                                input logic [23:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Loads the register set for one phase; the block is idle when this is called.
  task automatic program_phase(input int phase);
    int idx;
    case (phase)
      0: begin
        write_register(dpt_pkg::CFG_CENTER_X, 24'd0);
        write_register(dpt_pkg::CFG_CENTER_Y, 24'd0);
        write_register(dpt_pkg::CFG_INV_FOCAL_X, 24'hFFFFFF);
        write_register(dpt_pkg::CFG_INV_FOCAL_Y, 24'hFFFFFF);
        write_register(dpt_pkg::CFG_COLOR_ENABLE, 24'd0);
      end
      1: begin
        write_register(dpt_pkg::CFG_CENTER_X, 24'd163839);
        write_register(dpt_pkg::CFG_CENTER_Y, 24'd122879);
        write_register(dpt_pkg::CFG_INV_FOCAL_X, 24'd0);
        write_register(dpt_pkg::CFG_INV_FOCAL_Y, 24'd0);
        write_register(dpt_pkg::CFG_COLOR_ENABLE, 24'd1);
      end
      2: begin
        write_register(dpt_pkg::CFG_CENTER_X, 24'($urandom_range(300 * 256, 340 * 256)));
        write_register(dpt_pkg::CFG_CENTER_Y, 24'($urandom_range(220 * 256, 260 * 256)));
        write_register(dpt_pkg::CFG_INV_FOCAL_X, 24'($urandom_range(25000, 40000)));
        write_register(dpt_pkg::CFG_INV_FOCAL_Y, 24'($urandom_range(25000, 40000)));
        write_register(dpt_pkg::CFG_COLOR_ENABLE, 24'($urandom_range(0, 1)));
      end
      3: begin
        // Full-width data exercises the masking; writes to unused indexes must be dropped.
        write_register(dpt_pkg::CFG_CENTER_X, 24'($urandom()));
        write_register(dpt_pkg::CFG_CENTER_Y, 24'($urandom()));
        write_register(dpt_pkg::CFG_INV_FOCAL_X, 24'($urandom()));
        write_register(dpt_pkg::CFG_INV_FOCAL_Y, 24'($urandom()));
        write_register(dpt_pkg::CFG_COLOR_ENABLE, 24'($urandom()));
        for (idx = int'(dpt_pkg::CFG_COLOR_ENABLE) + 1; idx < (1 << dpt_pkg::CFG_IDX_W);
             idx++) begin
          write_register(idx[dpt_pkg::CFG_IDX_W-1:0], 24'($urandom()));
        end
      end
      4: begin
        write_register(dpt_pkg::CFG_CENTER_X, 24'd80304);
        write_register(dpt_pkg::CFG_CENTER_Y, 24'd66309);
        write_register(dpt_pkg::CFG_INV_FOCAL_X, 24'd31873);
        write_register(dpt_pkg::CFG_INV_FOCAL_Y, 24'd31873);
        write_register(dpt_pkg::CFG_COLOR_ENABLE, 24'd1);
      end
      default: begin
        write_register(dpt_pkg::CFG_CENTER_X, 24'($urandom_range(0, 163839)));
        write_register(dpt_pkg::CFG_CENTER_Y, 24'($urandom_range(0, 122879)));
        write_register(dpt_pkg::CFG_INV_FOCAL_X, 24'($urandom_range(0, 24'hFFFFFF)));
        write_register(dpt_pkg::CFG_INV_FOCAL_Y, 24'($urandom_range(0, 24'hFFFFFF)));
        write_register(dpt_pkg::CFG_COLOR_ENABLE, 24'($urandom_range(0, 1)));
      end
    endcase
    cfg_we <= 1'b0;
  endtask

  // Random pixels, mostly inside the image, with some zero, tiny and full-scale depths.
  // Halfway through, the receiver is asked for a long hold so the pipeline backs up.
  task automatic run_random_pixels(input int count);
    int          i;
    logic [9:0]  u;
    logic [8:0]  v;
    logic [15:0] d;
    for (i = 0; i < count; i++) begin
      if (i == count / 2) hold_request = 1'b1;
      u = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(0, 1023))
                                      : 10'($urandom_range(0, 639));
      v = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(0, 511))
                                      : 9'($urandom_range(0, 479));
      case ($urandom_range(0, 7))
        0:       d = 16'd0;
        1:       d = 16'hFFFF;
        2:       d = 16'($urandom_range(0, 255));
        default: d = 16'($urandom());
      endcase
      send_pixel(1'($urandom_range(0, 1)), u, v, d, 8'($urandom()), 8'($urandom()),
                 8'($urandom()));
    end
  endtask

  // Result side: random stalls per transaction, steady stretches, and the long hold.
  initial begin : result_sink
    int stall;
    int taken;
    taken = 0;
    out_ready = 1'b0;
    receiver_steady = 1'b0;
    forever begin
      if (taken % 48 == 0) receiver_steady = ($urandom_range(0, 3) == 0);
      taken++;
      if (hold_request) begin
        stall = LONG_HOLD;
        hold_request = 1'b0;
      end else if (receiver_steady) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 9);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Ends the run if no transaction moves on either channel for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    int phase;
    hold_request     = 1'b0;
    sender_steady    = 1'b0;
    pixels_sent      = 0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_wdata        = '0;
    in_valid         = 1'b0;
    in_camera_select = 1'b0;
    in_column        = '0;
    in_row           = '0;
    in_depth         = '0;
    in_first_byte    = '0;
    in_second_byte   = '0;
    in_third_byte    = '0;
    rst_n            = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pixels on the reset configuration: zero depth, image corners,
    // just outside the image, the widest column and row, and the optical center.
    send_pixel(1'b0, 10'd0, 9'd0, 16'd0, 8'h00, 8'h00, 8'h00);
    send_pixel(1'b1, 10'd0, 9'd0, 16'd0, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(1'b0, 10'd1023, 9'd511, 16'hFFFF, 8'hFF, 8'h00, 8'hFF);
    send_pixel(1'b1, 10'd1023, 9'd511, 16'hFFFF, 8'h00, 8'hFF, 8'h00);
    send_pixel(1'b0, 10'd639, 9'd479, 16'd1000, 8'h12, 8'h34, 8'h56);
    send_pixel(1'b1, 10'd639, 9'd479, 16'd1000, 8'h56, 8'h34, 8'h12);
    send_pixel(1'b0, 10'd640, 9'd480, 16'd1000, 8'hAA, 8'h55, 8'h0F);
    send_pixel(1'b1, 10'd640, 9'd480, 16'd1, 8'hF0, 8'hA5, 8'h5A);
    send_pixel(1'b0, 10'd314, 9'd259, 16'd4000, 8'h01, 8'h02, 8'h03);
    send_pixel(1'b1, 10'd314, 9'd259, 16'd4000, 8'h80, 8'h40, 8'h20);
    send_pixel(1'b0, 10'd0, 9'd479, 16'hFFFF, 8'h7F, 8'hFE, 8'h01);
    send_pixel(1'b1, 10'd0, 9'd479, 16'hFFFF, 8'hC3, 8'h3C, 8'h99);
    send_pixel(1'b0, 10'd1, 9'd1, 16'd1, 8'h00, 8'hFF, 8'h00);
    send_pixel(1'b1, 10'd512, 9'd256, 16'h8000, 8'hAA, 8'h55, 8'h0F);
    send_pixel(1'b0, 10'd639, 9'd0, 16'h7FFF, 8'h11, 8'h22, 8'h33);
    send_pixel(1'b1, 10'd0, 9'd511, 16'd2, 8'h44, 8'h55, 8'h66);
    wait_drained();

    for (phase = 0; phase < PHASES; phase++) begin
      program_phase(phase);
      run_random_pixels(PHASE_ITEMS);
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: depth_pixel_to_point_transform_unit.f
src/dpt_pkg.sv
src/dpt_cfg.sv
src/dpt_proj.sv
src/dpt_rot.sv
src/depth_pixel_to_point_transform_unit.sv
bench/point_stream_checker.sv
bench/depth_pixel_to_point_transform_unit_tb.sv
